// File: rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// i2cms_pkg: command codes, fixed widths and controller/datapath link types
// for the i2c master bit sequencer; depends on nothing

package i2cms_pkg;

  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int BIT_CNT_W = $clog2(BYTE_W);
  localparam int STEP_W = 2;

  // bus command codes
  localparam logic [KIND_W-1:0] K_START = 3'd0;
  localparam logic [KIND_W-1:0] K_STOP  = 3'd1;
  localparam logic [KIND_W-1:0] K_WRITE = 3'd2;
  localparam logic [KIND_W-1:0] K_RACK  = 3'd3;
  localparam logic [KIND_W-1:0] K_SACK  = 3'd4;
  localparam logic [KIND_W-1:0] K_PROBE = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture byte and sample of the accepted item
    logic emit;     // produce one phase
    logic set_scl;  // this phase changes the clock line
    logic set_sda;  // this phase changes the data line
    logic lvl;      // new level for the changed line
    logic use_bit;  // data level comes from the shift register msb
    logic shift;    // move to the next data bit
    logic last;     // final phase of the command
    logic nack_en;  // final phase reports the sampled ack
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // output register can take a phase this cycle
  } sts_t;

endpackage

// File: rtl/i2cms_if.sv
`timescale 1ns / 1ps
// i2cms_in_if / i2cms_out_if: valid/ready channels of the i2c sequencer
// widths follow the command and phase fields; no other dependency

interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       sda_sample;

  modport source (output valid, output kind, output data_byte, output sda_sample,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input sda_sample,
                output ready);
endinterface

interface i2cms_out_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda;
  logic nack;
  logic last;

  modport source (output valid, output scl, output sda, output nack, output last,
                  input ready);
  modport sink (input valid, input scl, input sda, input nack, input last,
                output ready);
endinterface

// File: rtl/i2cms_ctrl.sv
`timescale 1ns / 1ps
// i2cms_ctrl: command sequencer state machine, one phase per step
// depends on i2cms_pkg; drives i2cms_dp through cmd_t, reads sts_t

module i2cms_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [i2cms_pkg::KIND_W-1:0]  in_kind,
  output logic                          in_ready,
  input  i2cms_pkg::sts_t               sts,
  output i2cms_pkg::cmd_t               cmd
);
  import i2cms_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_STOP  = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_RACK  = 6'b010000,
    ST_SACK  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic                 probe_r, probe_nxt;
  logic                 fin_r, fin_nxt;
  logic                 seg_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      bit_cnt_r <= '0;
      probe_r   <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      probe_r   <= probe_nxt;
      fin_r     <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    bit_cnt_nxt = bit_cnt_r;
    probe_nxt   = probe_r;
    fin_nxt     = fin_r;
    in_ready    = 1'b0;
    seg_end     = 1'b0;
    cmd         = '0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        step_nxt = '0;
        bit_cnt_nxt = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          probe_nxt = 1'b0;
          fin_nxt   = 1'b0;
          case (in_kind)
            K_START: state_nxt = ST_START;
            K_STOP:  state_nxt = ST_STOP;
            K_WRITE: state_nxt = ST_WRITE;
            K_RACK:  state_nxt = ST_RACK;
            K_SACK:  state_nxt = ST_SACK;
            K_PROBE: begin
              state_nxt = ST_STOP;
              probe_nxt = 1'b1;
            end
            default: state_nxt = ST_IDLE; // unused codes produce nothing
          endcase
        end
      end
      ST_START: begin
        // sda 1, scl 1, sda 0, scl 0
        cmd.set_sda = ~step_r[0];
        cmd.set_scl = step_r[0];
        cmd.lvl     = ~step_r[1];
        seg_end     = (step_r == 2'd3);
      end
      ST_STOP: begin
        // scl 0, sda 0, scl 1, sda 1
        cmd.set_scl = ~step_r[0];
        cmd.set_sda = step_r[0];
        cmd.lvl     = step_r[1];
        seg_end     = (step_r == 2'd3);
      end
      ST_WRITE: begin
        // scl 0, then per bit: sda bit, scl 1, scl 0
        case (step_r)
          2'd1: begin
            cmd.set_sda = 1'b1;
            cmd.use_bit = 1'b1;
          end
          2'd2: begin
            cmd.set_scl = 1'b1;
            cmd.lvl     = 1'b1;
          end
          default: begin
            cmd.set_scl = 1'b1;
            cmd.lvl     = 1'b0;
          end
        endcase
        seg_end = (step_r == 2'd3) && (bit_cnt_r == BIT_CNT_W'(BYTE_W - 1));
      end
      ST_RACK: begin
        // sda released, scl 1, scl 0
        cmd.set_sda = (step_r == 2'd0);
        cmd.set_scl = (step_r != 2'd0);
        cmd.lvl     = (step_r != 2'd2);
        seg_end     = (step_r == 2'd2);
      end
      ST_SACK: begin
        // sda 0, scl 1, scl 0, sda 1
        cmd.set_sda = (step_r == 2'd0) || (step_r == 2'd3);
        cmd.set_scl = (step_r == 2'd1) || (step_r == 2'd2);
        cmd.lvl     = (step_r == 2'd1) || (step_r == 2'd3);
        seg_end     = (step_r == 2'd3);
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (state_r != ST_IDLE) begin
      cmd.last    = seg_end && (!probe_r || ((state_r == ST_STOP) && fin_r));
      cmd.nack_en = cmd.last && (probe_r || (state_r == ST_RACK));
      if (!sts.out_free) begin
        // hold everything until the output register frees up
        cmd = '0;
      end else begin
        cmd.emit = 1'b1;
        cmd.shift = (state_r == ST_WRITE) && (step_r == 2'd3);
        step_nxt = step_r + 2'd1;
        if ((state_r == ST_WRITE) && (step_r == 2'd3) && !seg_end) begin
          step_nxt    = 2'd1;
          bit_cnt_nxt = bit_cnt_r + 1'b1;
        end
        if (seg_end) begin
          step_nxt    = '0;
          bit_cnt_nxt = '0;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end else begin
            // probe chain: stop, start, write, read ack, stop
            case (state_r)
              ST_STOP:  state_nxt = ST_START;
              ST_START: state_nxt = ST_WRITE;
              ST_WRITE: state_nxt = ST_RACK;
              ST_RACK: begin
                state_nxt = ST_STOP;
                fin_nxt   = 1'b1;
              end
              default:  state_nxt = ST_IDLE;
            endcase
          end
        end
      end
    end
  end

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && in_valid && (in_kind <= K_PROBE) |=> state_r != ST_IDLE)
    else $error("valid command did not start a run");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last && cmd.emit |=> state_r == ST_IDLE)
    else $error("sequencer kept running after final phase");

  a_bit_cnt_in_write: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r != '0 |-> state_r == ST_WRITE)
    else $error("bit counter live outside a byte write");

endmodule

// File: rtl/i2cms_dp.sv
`timescale 1ns / 1ps
// i2cms_dp: line levels, data shift register, ack sample and output register
// depends on i2cms_pkg; controlled by i2cms_ctrl

module i2cms_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  i2cms_pkg::cmd_t               cmd,
  output i2cms_pkg::sts_t               sts,
  input  logic [i2cms_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                          in_sda_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_scl,
  output logic                          out_sda,
  output logic                          out_nack,
  output logic                          out_last
);
  import i2cms_pkg::*;

  logic              scl_r, sda_r;
  logic [BYTE_W-1:0] shift_r;
  logic              sample_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_scl_r, out_sda_r, out_nack_r, out_last_r;
  logic              scl_new, sda_new;

  assign scl_new = cmd.set_scl ? cmd.lvl : scl_r;
  assign sda_new = cmd.set_sda ? (cmd.use_bit ? shift_r[BYTE_W-1] : cmd.lvl) : sda_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.emit) begin
        scl_r <= scl_new;
        sda_r <= sda_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift_r  <= in_data_byte;
      sample_r <= in_sda_sample;
    end else if (cmd.shift) begin
      shift_r <= {shift_r[BYTE_W-2:0], 1'b0};
    end
    if (cmd.emit) begin
      out_scl_r  <= scl_new;
      out_sda_r  <= sda_new;
      out_nack_r <= cmd.nack_en && sample_r;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_scl   = out_scl_r;
  assign out_sda   = out_sda_r;
  assign out_nack  = out_nack_r;
  assign out_last  = out_last_r;

  a_nack_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_nack_r |-> out_last_r)
    else $error("nack flagged on a phase that is not final");

  a_one_line_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (scl_r == $past(scl_r)) || (sda_r == $past(sda_r)))
    else $error("both lines changed in one phase");

  a_idle_high_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> scl_r && sda_r)
    else $error("lines not released after reset");

endmodule

// File: rtl/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// i2c_master_bit_sequencer: top level of the i2c master bit sequencer
// depends on i2cms_pkg, i2cms_if, i2cms_ctrl and i2cms_dp
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------
//  in_ch    | in  | valid/ready         | kind[2:0] data_byte[7:0] sda_sample
//  out_ch   | out | valid/ready         | scl sda nack last (one item per phase)
//
// a command is accepted, then emits one output item per line phase:
// start 4, stop 4, write byte 25, read ack 3, send ack 4, probe 40 phases
// the sequencer state machine emits at most one phase per cycle into a single
// output register; a stalled output holds the sequencer on that phase
// kinds 6 and 7 are taken and dropped without any phase
// reset (synchronous, active low) leaves both lines released high and idle

module i2c_master_bit_sequencer (
  input  logic         clk,
  input  logic         rst_n,
  i2cms_in_if.sink     in_ch,
  i2cms_out_if.source  out_ch
);
  import i2cms_pkg::*;

  cmd_t cmd;  // controller to datapath
  sts_t sts;  // datapath back to controller

  // sequencer: walks the phases of each command, chaining runs for a probe
  i2cms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: line state, byte shifter, ack sample, phase output register
  i2cms_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data_byte  (in_ch.data_byte),
    .in_sda_sample (in_ch.sda_sample),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_scl       (out_ch.scl),
    .out_sda       (out_ch.sda),
    .out_nack      (out_ch.nack),
    .out_last      (out_ch.last)
  );

endmodule
